>>> rtl/pfm_pkg.sv
// shared constants, codes and list control types for the page frame manager
package pfm_pkg;

    localparam int NUM_PAGES       = 256;
    localparam int NUM_FRAMES      = 64;
    localparam int NUM_SWAP_FRAMES = 256;

    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 6;
    localparam int SWAP_W  = 8;
    localparam int COUNT_W = 7;
    localparam int SCAN_W  = 9;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 9;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SWAP = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CIDX_W-1:0] REG_REAL   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_SWAP   = 2'd2;

    localparam logic POLICY_LRU = 1'b0;

    typedef enum logic [1:0] {
        LOP_NONE,
        LOP_SHIFT,
        LOP_WRITE
    } list_op_t;

    typedef struct packed {
        list_op_t             op;
        logic [FRAME_W-1:0]   idx;
        logic [PAGE_W-1:0]    wdata;
        logic [PAGE_W-1:0]    key;
        logic [COUNT_W-1:0]   count;
    } list_ctl_t;

    typedef struct packed {
        logic                 found;
        logic [FRAME_W-1:0]   match_idx;
        logic [PAGE_W-1:0]    rd_data;
    } list_stat_t;

endpackage

>>> rtl/page_frame_manager_lru_clock_core.sv
// page frame manager with lru or clock replacement, top level
//
// Input beats (s_cmd, s_page) allocate, access or free one page; each gives
// exactly one result beat on the m_ channel with the frame moves it caused.
// Registers policy, real_frame_count and swap_frame_count are written on
// the cfg_ channel (cfg_index, cfg_data), always ready; the user must write
// them only while idle, as the block itself does not enforce it.
// One item is worked on at a time. A hit under clock goes straight to the
// result; under lru it also looks up the page, shifts it out of the resident
// cell row and writes it back at the tail.
// A placement scans the real frame busy map one frame per cycle, and when
// all are taken the swap busy map one frame per cycle, then under lru
// evicts the list head and under clock sweeps from the hand.
// The bitmap scan and the clock sweep set the latency.
// Reset (aresetn low, synchronous) clears all page bits, busy maps, list
// count, clock hand and the result register; registers return to lru,
// 64 real and 256 swap frames. A finished result waits in the output
// register while the next beat is taken; a stalled receiver holds the
// block once a second result is ready.
module page_frame_manager_lru_clock_core import pfm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [PAGE_W-1:0]   s_page,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [FRAME_W-1:0]  m_frame,
    output logic                m_swapped_in,
    output logic [SWAP_W-1:0]   m_source_swap_frame,
    output logic                m_evicted,
    output logic [PAGE_W-1:0]   m_victim_page,
    output logic [SWAP_W-1:0]   m_victim_swap_frame,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CDATA_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_FIND, S_REMOVE, S_APPEND, S_SCAN_REAL, S_SCAN_SWAP,
        S_PLACE, S_LRU_EVICT, S_SWEEP, S_VREAD, S_VDONE, S_PWRITE, S_FAIL, S_DONE
    } state_t;

    typedef enum logic [1:0] {M_FREE, M_HIT, M_PLACE} mode_t;

    state_t state_reg;
    mode_t  mode_reg;

    logic                 policy_reg;
    logic [COUNT_W-1:0]   real_cnt_reg;
    logic [SCAN_W-1:0]    swap_cnt_reg;

    logic [NUM_PAGES-1:0]       valid_reg, present_reg, use_reg;
    logic [NUM_FRAMES-1:0]      real_busy_reg;
    logic [NUM_SWAP_FRAMES-1:0] swap_busy_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic [FRAME_W-1:0]         hand_reg;

    logic [CMD_W-1:0]   cmd_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [SWAP_W-1:0]  loc_reg;
    logic               swapin_reg;
    logic [SCAN_W-1:0]  scan_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] idx_reg;
    logic [SWAP_W-1:0]  swap_reg;
    logic [PAGE_W-1:0]  victim_reg;

    // pending result fields
    logic [STAT_W-1:0]  res_status_reg;
    logic [FRAME_W-1:0] res_frame_reg;
    logic               res_swapped_in_reg;
    logic [SWAP_W-1:0]  res_src_reg;
    logic               res_evicted_reg;
    logic [PAGE_W-1:0]  res_victim_reg;
    logic [SWAP_W-1:0]  res_vswap_reg;

    // output register
    logic               m_valid_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic [FRAME_W-1:0] m_frame_reg;
    logic               m_swapped_in_reg;
    logic [SWAP_W-1:0]  m_src_reg;
    logic               m_evicted_reg;
    logic [PAGE_W-1:0]  m_victim_reg;
    logic [SWAP_W-1:0]  m_vswap_reg;

    logic [COUNT_W-1:0] eff_real;
    logic [SCAN_W-1:0]  eff_swap;
    logic               mem_we;
    logic [PAGE_W-1:0]  mem_addr;
    logic [SWAP_W-1:0]  mem_wdata;
    logic [SWAP_W-1:0]  mem_rdata;
    list_ctl_t          lctl;
    list_stat_t         lstat;
    logic [FRAME_W-1:0] hand_adv;
    logic [COUNT_W-1:0] count_dec;
    logic               in_acc;
    logic               out_load;

    assign in_acc    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign count_dec = count_reg - COUNT_W'(1);

    // effective frame counts saturate at the table sizes
    assign eff_real = (real_cnt_reg > COUNT_W'(NUM_FRAMES)) ? COUNT_W'(NUM_FRAMES)
                                                            : real_cnt_reg;
    assign eff_swap = (swap_cnt_reg > SCAN_W'(NUM_SWAP_FRAMES)) ? SCAN_W'(NUM_SWAP_FRAMES)
                                                                : swap_cnt_reg;

    // clock hand step with wrap at the list length
    assign hand_adv = ({1'b0, hand_reg} + COUNT_W'(1) >= count_reg) ? '0
                                                                   : hand_reg + FRAME_W'(1);

    // location store port
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = page_reg;
        mem_wdata = '0;
        case (state_reg)
            S_IDLE:  mem_addr = s_page;
            S_PLACE: begin
                mem_we    = 1'b1;
                mem_wdata = SWAP_W'(scan_reg[FRAME_W-1:0]);
            end
            S_VREAD: mem_addr = victim_reg;
            S_VDONE: begin
                mem_we    = 1'b1;
                mem_addr  = victim_reg;
                mem_wdata = swap_reg;
            end
            S_PWRITE: begin
                mem_we    = 1'b1;
                mem_wdata = SWAP_W'(frame_reg);
            end
            default: begin
            end
        endcase
    end

    // resident list control
    always_comb begin
        lctl       = '0;
        lctl.op    = LOP_NONE;
        lctl.key   = page_reg;
        lctl.count = count_reg;
        lctl.wdata = page_reg;
        case (state_reg)
            S_REMOVE: begin
                lctl.op  = LOP_SHIFT;
                lctl.idx = idx_reg;
            end
            S_APPEND, S_PLACE: begin
                lctl.idx = count_reg[FRAME_W-1:0];
                if (count_reg < COUNT_W'(NUM_FRAMES)) lctl.op = LOP_WRITE;
            end
            S_LRU_EVICT: begin
                lctl.op  = LOP_SHIFT;
                lctl.idx = '0;
            end
            S_SWEEP: begin
                lctl.idx = hand_reg;
                if (!use_reg[lstat.rd_data]) lctl.op = LOP_WRITE;
            end
            default: begin
            end
        endcase
    end

    pfm_list u_list (
        .aclk (aclk),
        .ctl  (lctl),
        .stat (lstat)
    );

    pfm_loc_ram u_loc (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // control sequencer, page table bits and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_HIT;
            policy_reg    <= POLICY_LRU;
            real_cnt_reg  <= COUNT_W'(64);
            swap_cnt_reg  <= SCAN_W'(256);
            valid_reg     <= '0;
            present_reg   <= '0;
            use_reg       <= '0;
            real_busy_reg <= '0;
            swap_busy_reg <= '0;
            count_reg     <= '0;
            hand_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // configuration beat
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_POLICY: policy_reg   <= cfg_data[0];
                    REG_REAL:   real_cnt_reg <= cfg_data[COUNT_W-1:0];
                    REG_SWAP:   swap_cnt_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end

            if (m_valid_reg && m_ready && !out_load) m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        cmd_reg            <= s_cmd;
                        page_reg           <= s_page;
                        res_status_reg     <= ST_OK;
                        res_frame_reg      <= '0;
                        res_swapped_in_reg <= 1'b0;
                        res_src_reg        <= '0;
                        res_evicted_reg    <= 1'b0;
                        res_victim_reg     <= '0;
                        res_vswap_reg      <= '0;
                        state_reg          <= S_DISP;
                    end
                end

                // location of the page is now on the read port
                S_DISP: begin
                    loc_reg  <= mem_rdata;
                    scan_reg <= '0;
                    if (cmd_reg != CMD_ALLOC && cmd_reg != CMD_ACCESS
                        && cmd_reg != CMD_FREE) begin
                        state_reg <= S_DONE;
                    end else if (cmd_reg != CMD_ALLOC && !valid_reg[page_reg]) begin
                        res_status_reg <= ST_INVALID;
                        state_reg      <= S_DONE;
                    end else if (cmd_reg == CMD_ALLOC && !valid_reg[page_reg]) begin
                        mode_reg   <= M_PLACE;
                        swapin_reg <= 1'b0;
                        state_reg  <= S_SCAN_REAL;
                    end else if (cmd_reg == CMD_FREE) begin
                        valid_reg[page_reg]   <= 1'b0;
                        present_reg[page_reg] <= 1'b0;
                        use_reg[page_reg]     <= 1'b0;
                        mode_reg              <= M_FREE;
                        if (present_reg[page_reg]) begin
                            if (mem_rdata < SWAP_W'(NUM_FRAMES))
                                real_busy_reg[mem_rdata[FRAME_W-1:0]] <= 1'b0;
                            state_reg <= S_FIND;
                        end else begin
                            swap_busy_reg[mem_rdata] <= 1'b0;
                            state_reg <= S_DONE;
                        end
                    end else if (present_reg[page_reg]) begin
                        use_reg[page_reg] <= 1'b1;
                        res_frame_reg     <= mem_rdata[FRAME_W-1:0];
                        mode_reg          <= M_HIT;
                        state_reg         <= (policy_reg == POLICY_LRU) ? S_FIND : S_DONE;
                    end else begin
                        mode_reg   <= M_PLACE;
                        swapin_reg <= 1'b1;
                        state_reg  <= S_SCAN_REAL;
                    end
                end

                S_FIND: begin
                    idx_reg   <= lstat.match_idx;
                    state_reg <= lstat.found ? S_REMOVE : S_DONE;
                end

                S_REMOVE: begin
                    count_reg <= count_dec;
                    if (mode_reg == M_FREE) begin
                        if ({1'b0, hand_reg} >= count_dec) hand_reg <= '0;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_APPEND;
                    end
                end

                S_APPEND: begin
                    if (count_reg < COUNT_W'(NUM_FRAMES)) count_reg <= count_reg + COUNT_W'(1);
                    state_reg <= (mode_reg == M_HIT) ? S_DONE : S_VREAD;
                end

                // lowest free real frame, one per cycle
                S_SCAN_REAL: begin
                    if (scan_reg < SCAN_W'(eff_real)) begin
                        if (!real_busy_reg[scan_reg[FRAME_W-1:0]]) state_reg <= S_PLACE;
                        else scan_reg <= scan_reg + SCAN_W'(1);
                    end else if (count_reg == '0) begin
                        state_reg <= S_FAIL;
                    end else begin
                        scan_reg  <= '0;
                        state_reg <= S_SCAN_SWAP;
                    end
                end

                // lowest free swap frame, own swap frame counts as released
                S_SCAN_SWAP: begin
                    if (scan_reg < eff_swap) begin
                        if (!swap_busy_reg[scan_reg[SWAP_W-1:0]]
                            || (swapin_reg && scan_reg[SWAP_W-1:0] == loc_reg)) begin
                            swap_reg <= scan_reg[SWAP_W-1:0];
                            if (policy_reg == POLICY_LRU) begin
                                state_reg <= S_LRU_EVICT;
                            end else begin
                                if ({1'b0, hand_reg} >= count_reg) hand_reg <= '0;
                                state_reg <= S_SWEEP;
                            end
                        end else begin
                            scan_reg <= scan_reg + SCAN_W'(1);
                        end
                    end else begin
                        state_reg <= S_FAIL;
                    end
                end

                // free frame found: take it and join the list tail
                S_PLACE: begin
                    real_busy_reg[scan_reg[FRAME_W-1:0]] <= 1'b1;
                    if (count_reg < COUNT_W'(NUM_FRAMES)) count_reg <= count_reg + COUNT_W'(1);
                    res_frame_reg         <= scan_reg[FRAME_W-1:0];
                    valid_reg[page_reg]   <= 1'b1;
                    present_reg[page_reg] <= 1'b1;
                    use_reg[page_reg]     <= 1'b1;
                    if (swapin_reg) begin
                        swap_busy_reg[loc_reg] <= 1'b0;
                        res_swapped_in_reg     <= 1'b1;
                        res_src_reg            <= loc_reg;
                    end
                    state_reg <= S_DONE;
                end

                // lru victim is the list head
                S_LRU_EVICT: begin
                    victim_reg <= lstat.rd_data;
                    count_reg  <= count_dec;
                    state_reg  <= S_APPEND;
                end

                // second chance sweep from the hand
                S_SWEEP: begin
                    hand_reg <= hand_adv;
                    if (use_reg[lstat.rd_data]) begin
                        use_reg[lstat.rd_data] <= 1'b0;
                    end else begin
                        victim_reg <= lstat.rd_data;
                        state_reg  <= S_VREAD;
                    end
                end

                S_VREAD: state_reg <= S_VDONE;

                // victim goes to swap, its frame passes to the page
                S_VDONE: begin
                    frame_reg               <= mem_rdata[FRAME_W-1:0];
                    present_reg[victim_reg] <= 1'b0;
                    if (swapin_reg) begin
                        swap_busy_reg <= (swap_busy_reg & ~(NUM_SWAP_FRAMES'(1) << loc_reg))
                                         | (NUM_SWAP_FRAMES'(1) << swap_reg);
                    end else begin
                        swap_busy_reg[swap_reg] <= 1'b1;
                    end
                    res_frame_reg           <= mem_rdata[FRAME_W-1:0];
                    res_evicted_reg         <= 1'b1;
                    res_victim_reg          <= victim_reg;
                    res_vswap_reg           <= swap_reg;
                    state_reg               <= S_PWRITE;
                end

                S_PWRITE: begin
                    valid_reg[page_reg]   <= 1'b1;
                    present_reg[page_reg] <= 1'b1;
                    use_reg[page_reg]     <= 1'b1;
                    if (swapin_reg) begin
                        res_swapped_in_reg <= 1'b1;
                        res_src_reg        <= loc_reg;
                    end
                    state_reg <= S_DONE;
                end

                S_FAIL: begin
                    res_status_reg <= ST_NO_SWAP;
                    state_reg      <= S_DONE;
                end

                // hand the result to the output register
                S_DONE: begin
                    if (out_load) begin
                        m_valid_reg      <= 1'b1;
                        m_status_reg     <= res_status_reg;
                        m_frame_reg      <= res_frame_reg;
                        m_swapped_in_reg <= res_swapped_in_reg;
                        m_src_reg        <= res_src_reg;
                        m_evicted_reg    <= res_evicted_reg;
                        m_victim_reg     <= res_victim_reg;
                        m_vswap_reg      <= res_vswap_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_frame             = m_frame_reg;
    assign m_swapped_in        = m_swapped_in_reg;
    assign m_source_swap_frame = m_src_reg;
    assign m_evicted           = m_evicted_reg;
    assign m_victim_page       = m_victim_reg;
    assign m_victim_swap_frame = m_vswap_reg;

`ifndef SYNTH
    // list never grows past the frame table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(NUM_FRAMES))
        else $error("resident count above frame table size");

    // every busy real frame holds exactly one listed page
    a_count_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (32'(count_reg) == $countones(real_busy_reg)))
        else $error("resident count differs from busy real frames");

    // a result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && state_reg == S_DONE) |=> (state_reg == S_DONE))
        else $error("result loaded over a stalled beat");
`endif

endmodule

>>> rtl/pfm_cell.sv
// one entry of the resident page list
module pfm_cell import pfm_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  list_ctl_t           ctl,
    input  logic [PAGE_W-1:0]   next_data,
    output logic [PAGE_W-1:0]   data,
    output logic                match
);

    logic [PAGE_W-1:0] cell_reg;
    logic [PAGE_W-1:0] cell_next;

    // shift from the upper neighbor or take a written page
    always_comb begin
        cell_next = cell_reg;
        case (ctl.op)
            LOP_SHIFT: begin
                if (FRAME_W'(IDX) >= ctl.idx) cell_next = next_data;
            end
            LOP_WRITE: begin
                if (FRAME_W'(IDX) == ctl.idx) cell_next = ctl.wdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
    end

    assign data  = cell_reg;
    assign match = (COUNT_W'(IDX) < ctl.count) && (cell_reg == ctl.key);

endmodule

>>> rtl/pfm_list.sv
// resident page list as a row of cells with lookup and indexed read
module pfm_list import pfm_pkg::*; (
    input  logic        aclk,
    input  list_ctl_t   ctl,
    output list_stat_t  stat
);

    logic [PAGE_W-1:0] data [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] match;

    // cells, each fed by its upper neighbor
    for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
        logic [PAGE_W-1:0] nxt;
        if (i < NUM_FRAMES - 1) begin : g_mid
            assign nxt = data[i+1];
        end else begin : g_top
            assign nxt = data[i];
        end
        pfm_cell #(.IDX(i)) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .next_data (nxt),
            .data      (data[i]),
            .match     (match[i])
        );
    end

    // encode the match and read the indexed entry
    always_comb begin
        stat = '0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (match[i]) begin
                stat.found     = 1'b1;
                stat.match_idx = stat.match_idx | FRAME_W'(i);
            end
            if (FRAME_W'(i) == ctl.idx) stat.rd_data = stat.rd_data | data[i];
        end
    end

endmodule

>>> rtl/pfm_loc_ram.sv
// page location store, one port, registered read
module pfm_loc_ram import pfm_pkg::*; (
    input  logic                aclk,
    input  logic                we,
    input  logic [PAGE_W-1:0]   addr,
    input  logic [SWAP_W-1:0]   wdata,
    output logic [SWAP_W-1:0]   rdata
);

    logic [SWAP_W-1:0] mem [NUM_PAGES];

    // write and read at one address
    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

>>> tb/page_frame_manager_lru_clock_core_test.sv
// testbench for the page frame manager: random paging traffic checked against a predictor
module page_frame_manager_lru_clock_core_test;
    import pfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 450;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] frame;
        logic               swapped_in;
        logic [SWAP_W-1:0]  source_swap;
        logic               evicted;
        logic [PAGE_W-1:0]  victim_page;
        logic [SWAP_W-1:0]  victim_swap;
    } page_result_t;

    // page table predictor plus the queue of results still owed by the block
    class paging_scoreboard;
        bit                 pg_valid [NUM_PAGES];
        bit                 pg_present [NUM_PAGES];
        bit                 pg_use [NUM_PAGES];
        logic [7:0]         pg_loc [NUM_PAGES];
        bit                 real_taken [NUM_FRAMES];
        bit                 swap_taken [NUM_SWAP_FRAMES];
        logic [PAGE_W-1:0]  resident [NUM_FRAMES];
        int                 resident_len;
        int                 hand;
        bit                 clock_mode;
        int                 real_limit;
        int                 swap_limit;
        page_result_t       owed_q [$];
        int                 mismatches;

        function new();
            real_limit = NUM_FRAMES;
            swap_limit = NUM_SWAP_FRAMES;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
            case (idx)
                REG_POLICY: clock_mode = data[0];
                REG_REAL:   real_limit = (data[6:0] > NUM_FRAMES) ? NUM_FRAMES : data[6:0];
                REG_SWAP:   swap_limit = (data > NUM_SWAP_FRAMES) ? NUM_SWAP_FRAMES : data;
                default: ;
            endcase
        endfunction

        function void drop_at(int pos);
            for (int i = pos; i + 1 < resident_len; i++) resident[i] = resident[i + 1];
            resident_len--;
        endfunction

        function void bump_hand();
            hand++;
            if (hand >= resident_len) hand = 0;
        endfunction

        // find a frame for page p, evicting if needed; 1 means no room
        function int place_page(int p, ref page_result_t r);
            int f, s, v;
            f = -1;
            s = -1;
            for (int i = 0; i < real_limit; i++) if (!real_taken[i] && f < 0) f = i;
            if (f >= 0) begin
                real_taken[f] = 1;
                pg_loc[p] = 8'(f);
                if (resident_len < NUM_FRAMES) resident[resident_len++] = PAGE_W'(p);
                r.frame = FRAME_W'(f);
                return 0;
            end
            for (int i = 0; i < swap_limit; i++) if (!swap_taken[i] && s < 0) s = i;
            if (resident_len == 0 || s < 0) return 1;
            if (!clock_mode) begin
                v = resident[0];
                drop_at(0);
                resident[resident_len++] = PAGE_W'(p);
            end else begin
                if (hand >= resident_len) hand = 0;
                while (pg_use[resident[hand]]) begin
                    pg_use[resident[hand]] = 0;
                    bump_hand();
                end
                v = resident[hand];
                resident[hand] = PAGE_W'(p);
                bump_hand();
            end
            f = pg_loc[v];
            pg_present[v] = 0;
            pg_loc[v] = 8'(s);
            swap_taken[s] = 1;
            pg_loc[p] = 8'(f);
            r.frame = FRAME_W'(f);
            r.evicted = 1;
            r.victim_page = PAGE_W'(v);
            r.victim_swap = SWAP_W'(s);
            return 0;
        endfunction

        function void access_page(int p, ref page_result_t r);
            int loc;
            if (pg_present[p]) begin
                pg_use[p] = 1;
                if (!clock_mode) begin
                    for (int i = 0; i < resident_len; i++) begin
                        if (resident[i] == p) begin
                            drop_at(i);
                            resident[resident_len++] = PAGE_W'(p);
                            break;
                        end
                    end
                end
                r.frame = pg_loc[p][5:0];
                return;
            end
            // swap frame is released before placement so a victim may reuse it
            loc = pg_loc[p];
            swap_taken[loc] = 0;
            if (place_page(p, r) != 0) begin
                swap_taken[loc] = 1;
                r = '0;
                r.status = ST_NO_SWAP;
                return;
            end
            pg_present[p] = 1;
            pg_use[p] = 1;
            r.swapped_in = 1;
            r.source_swap = SWAP_W'(loc);
        endfunction

        function void free_page(int p);
            int loc;
            loc = pg_loc[p];
            if (pg_present[p]) begin
                real_taken[loc] = 0;
                for (int i = 0; i < resident_len; i++) begin
                    if (resident[i] == p) begin
                        drop_at(i);
                        if (hand >= resident_len) hand = 0;
                        break;
                    end
                end
            end else begin
                swap_taken[loc] = 0;
            end
            pg_valid[p] = 0;
            pg_present[p] = 0;
            pg_use[p] = 0;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
            page_result_t r;
            int p;
            r = '0;
            p = page;
            if (cmd == CMD_ALLOC && !pg_valid[p]) begin
                if (place_page(p, r) != 0) begin
                    r = '0;
                    r.status = ST_NO_SWAP;
                end else begin
                    pg_valid[p] = 1;
                    pg_present[p] = 1;
                    pg_use[p] = 1;
                end
            end else if (cmd != CMD_ALLOC && cmd != CMD_ACCESS && cmd != CMD_FREE) begin
                r = '0;
            end else if (!pg_valid[p]) begin
                r.status = ST_INVALID;
            end else if (cmd == CMD_FREE) begin
                free_page(p);
            end else begin
                access_page(p, r);
            end
            owed_q.push_back(r);
        endfunction

        function void check_result(page_result_t got);
            page_result_t want;
            bit bad;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = owed_q.pop_front();
            bad = (got.status != want.status) || (got.frame != want.frame)
                || (got.swapped_in != want.swapped_in) || (got.source_swap != want.source_swap)
                || (got.evicted != want.evicted) || (got.victim_page != want.victim_page)
                || (got.victim_swap != want.victim_swap);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) $display("result mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd;
    logic [PAGE_W-1:0]   s_page;
    logic                m_valid;
    logic                m_ready;
    logic [STAT_W-1:0]   m_status;
    logic [FRAME_W-1:0]  m_frame;
    logic                m_swapped_in;
    logic [SWAP_W-1:0]   m_source_swap_frame;
    logic                m_evicted;
    logic [PAGE_W-1:0]   m_victim_page;
    logic [SWAP_W-1:0]   m_victim_swap_frame;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CDATA_W-1:0]  cfg_data;

    paging_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;

    page_frame_manager_lru_clock_core dut (.*);

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // result side: check each beat, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result('{m_status, m_frame, m_swapped_in, m_source_swap_frame,
                              m_evicted, m_victim_page, m_victim_swap_frame});
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_page  <= page;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(cmd, page);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_q.size() != 0) @(posedge aclk);
    endtask

    // all three registers, written back to back once the block is quiet
    task automatic write_regs(bit pol, int nreal, int nswap);
        logic [CDATA_W-1:0] vals [3];
        logic [CIDX_W-1:0]  idxs [3];
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        idxs = '{REG_POLICY, REG_REAL, REG_SWAP};
        vals = '{CDATA_W'(pol), CDATA_W'(nreal), CDATA_W'(nswap)};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int cfg_pol [8];
        int cfg_real [8];
        int cfg_swap [8];
        int pool;
        int r;
        int sent;
        logic [CMD_W-1:0] c;

        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_cmd     <= CMD_ALLOC;
        s_page    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_POLICY;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, field extremes, every command, invalid and unused
        send_request(CMD_ALLOC, 8'd0);
        send_request(CMD_ALLOC, 8'd255);
        send_request(CMD_ACCESS, 8'd255);
        send_request(CMD_ALLOC, 8'd0);
        send_request(CMD_FREE, 8'd0);
        send_request(CMD_FREE, 8'd0);
        send_request(CMD_ACCESS, 8'd7);
        send_request(CMD_NONE, 8'd170);
        send_request(CMD_ALLOC, 8'd85);

        // directed: tiny memory forces eviction, swap in and no room for a victim
        write_regs(1'b0, 2, 2);
        send_request(CMD_ALLOC, 8'd1);
        send_request(CMD_ALLOC, 8'd2);
        send_request(CMD_ACCESS, 8'd255);
        send_request(CMD_ACCESS, 8'd85);
        send_request(CMD_ALLOC, 8'd3);
        send_request(CMD_ALLOC, 8'd4);
        send_request(CMD_FREE, 8'd1);
        send_request(CMD_ACCESS, 8'd4);
        write_regs(1'b1, 2, 2);
        send_request(CMD_ACCESS, 8'd85);
        send_request(CMD_ALLOC, 8'd5);
        send_request(CMD_ACCESS, 8'd2);
        send_request(CMD_FREE, 8'd3);
        send_request(CMD_FREE, 8'd255);

        // random phases over several settings, the extremes among them
        cfg_pol  = '{0, 1, 0, 1, 1, 0, 1, 0};
        cfg_real = '{4, 4, 1, 3, 64, 127, 0, 8};
        cfg_swap = '{6, 6, 1, 2, 256, 511, 0, 16};
        sent = 0;
        for (int ph = 0; ph < 8; ph++) begin
            write_regs(cfg_pol[ph], cfg_real[ph], cfg_swap[ph]);
            pool = ((cfg_real[ph] > 64) ? 64 : cfg_real[ph]) + cfg_swap[ph] / 4 + 3;
            if (pool > 90) pool = 90;
            for (int k = 0; k < 130; k++) begin
                send_idle_pct = (sent < 350) ? 14 : (sent < 700) ? 65 : 0;
                recv_idle_pct = (sent < 350) ? 65 : (sent < 700) ? 14 : 0;
                if (k == 65 && ph == 3) wait_drained();
                r = $urandom_range(99);
                c = (r < 40) ? CMD_ALLOC : (r < 75) ? CMD_ACCESS : (r < 97) ? CMD_FREE : CMD_NONE;
                if ($urandom_range(99) < 85) send_request(c, PAGE_W'($urandom_range(pool - 1)));
                else send_request(c, PAGE_W'($urandom_range(255)));
                sent++;
            end
        end

        // drain and report
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
